// ----- rtl/core/text_console_writer_unit_assert.svh -----
// Assertion macros for the text console writer.
// Depends on nothing; included by the top level.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Package for the text console writer: request and result types,
// character codes, request kinds and controller states. No dependencies.
package tcw_pkg;

    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 25;

    localparam logic [7:0] CODE_TERM    = 8'd0;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_req;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_out_res;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_CLEAR
    } t_state;

endpackage

// ----- rtl/core/text_console_writer_unit.sv -----
// Text console writer: screen store of COLS x ROWS cells with a cursor.
// Request channel i_valid/o_stall carries a tcw_pkg::t_in_req (put, clear, read);
// result channel o_valid/i_stall carries a tcw_pkg::t_out_res, one per request.
// Attribute register written over i_cfg_valid/o_cfg_ready (always ready).
// Latency: a put without scroll, a read or an ignored request gives its result
// the cycle after acceptance; one such request can be taken every cycle while no result waits on i_stall.
// A put that finds the cursor past the end scrolls first: the cell memory
// is copied one row up, one cell per cycle through its single write port,
// then the bottom row is filled.
// A clear writes every cell once. Requests stall meanwhile.
// After reset the memory is zeroed one cell per cycle
// with o_stall high; attribute writes are taken throughout.
// While a result waits on i_stall, o_stall stays high and no request enters.
// Depends on tcw_pkg, tcw_screen_ram and text_console_writer_unit_assert.svh.
module text_console_writer_unit #(
    parameter int COLS = tcw_pkg::COLS_DEFAULT,
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tcw_pkg::t_in_req   i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output tcw_pkg::t_out_res  o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    `include "text_console_writer_unit_assert.svh"

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CUR_W = $clog2(CELLS + 1);
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    localparam logic [AW-1:0]    ADDR_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0]    ADDR_BOT  = AW'(CELLS - COLS);
    localparam logic [AW-1:0]    ADDR_COLS = AW'(COLS);
    localparam logic [CUR_W-1:0] CUR_END   = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0] CUR_BOT   = CUR_W'(CELLS - COLS);
    localparam logic [CUR_W-1:0] CUR_COLS  = CUR_W'(COLS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLS - 1);

    tcw_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic             r_copy_v, n_copy_v;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [COL_W-1:0] r_col, n_col;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_attr;
    logic             r_out_valid, n_out_valid;
    logic             r_out_rd, n_out_rd;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [15:0]      mem_wdata, mem_q;

    logic             in_acc;
    logic [7:0]       adv_code;
    logic [CUR_W-1:0] adv_cursor;
    logic [COL_W-1:0] adv_col;

    tcw_screen_ram #(
        .DEPTH(CELLS),
        .AW   (AW),
        .DW   (16)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_q)
    );

    assign o_stall     = (r_state != tcw_pkg::ST_IDLE) || (r_out_valid && i_stall);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid          = r_out_valid;
    assign o_res.cursor_pos = 11'(r_cursor);
    assign o_res.cell_char  = r_out_rd ? mem_q[7:0] : 8'd0;
    assign o_res.cell_attr  = r_out_rd ? mem_q[15:8] : 8'd0;

    // cursor step for a newline or a printed character
    assign adv_code = (r_state == tcw_pkg::ST_IDLE) ? i_req.char_code : r_code;
    always_comb begin
        if (adv_code == tcw_pkg::CODE_NEWLINE) begin
            adv_cursor = r_cursor - CUR_W'(r_col) + CUR_COLS;
            adv_col    = '0;
        end else begin
            adv_cursor = r_cursor + CUR_W'(1);
            adv_col    = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_addr      <= '0;
            r_copy_v    <= 1'b0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_attr      <= tcw_pkg::ATTR_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_copy_v    <= n_copy_v;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr  <= n_waddr;
        r_code   <= n_code;
        r_out_rd <= n_out_rd;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_waddr     = r_waddr;
        n_copy_v    = r_copy_v;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_code      = r_code;
        n_out_rd    = r_out_rd;
        n_out_valid = r_out_valid && i_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;

        case (r_state)
            tcw_pkg::ST_INIT: begin
                mem_we = 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_state = tcw_pkg::ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = 1'b0;
                    case (i_req.kind)
                        tcw_pkg::KIND_PUT: begin
                            if (i_req.char_code == tcw_pkg::CODE_TERM) begin
                                n_out_valid = 1'b1;
                            end else if (r_cursor == CUR_END) begin
                                // scroll first, then place the code
                                n_out_valid = 1'b0;
                                n_state     = tcw_pkg::ST_COPY;
                                n_addr      = ADDR_COLS;
                                n_copy_v    = 1'b0;
                                n_code      = i_req.char_code;
                                n_cursor    = CUR_BOT;
                                n_col       = '0;
                            end else begin
                                if (i_req.char_code != tcw_pkg::CODE_NEWLINE) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = AW'(r_cursor);
                                    mem_wdata = {r_attr, i_req.char_code};
                                end
                                n_cursor = adv_cursor;
                                n_col    = adv_col;
                            end
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            n_out_valid = 1'b0;
                            n_state     = tcw_pkg::ST_CLEAR;
                            n_addr      = '0;
                        end
                        tcw_pkg::KIND_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(i_req.cell_index);
                            n_out_rd  = 32'(i_req.cell_index) < 32'(CELLS);
                        end
                        default: begin
                            n_out_rd = 1'b0;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_COPY: begin
                mem_re   = 1'b1;
                n_copy_v = 1'b1;
                n_waddr  = r_addr - ADDR_COLS;
                if (r_copy_v) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_waddr;
                    mem_wdata = mem_q;
                end
                if (r_addr == ADDR_LAST) begin
                    n_state = tcw_pkg::ST_FILL;
                    n_addr  = ADDR_BOT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            tcw_pkg::ST_FILL: begin
                mem_we = 1'b1;
                if (r_copy_v) begin
                    // drain the last copied cell
                    mem_waddr = r_waddr;
                    mem_wdata = mem_q;
                    n_copy_v  = 1'b0;
                end else begin
                    if (r_addr == ADDR_BOT && r_code != tcw_pkg::CODE_NEWLINE) begin
                        mem_wdata = {r_attr, r_code};
                    end else begin
                        mem_wdata = {r_attr, tcw_pkg::CODE_SPACE};
                    end
                    if (r_addr == ADDR_LAST) begin
                        n_state     = tcw_pkg::ST_IDLE;
                        n_addr      = '0;
                        n_cursor    = adv_cursor;
                        n_col       = adv_col;
                        n_out_valid = 1'b1;
                        n_out_rd    = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            tcw_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = {r_attr, tcw_pkg::CODE_SPACE};
                if (r_addr == ADDR_LAST) begin
                    n_state     = tcw_pkg::ST_IDLE;
                    n_addr      = '0;
                    n_cursor    = '0;
                    n_col       = '0;
                    n_out_valid = 1'b1;
                    n_out_rd    = 1'b0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            default: begin
                n_state = tcw_pkg::ST_INIT;
                n_addr  = '0;
            end
        endcase
    end

    `TCW_ASSERT_SAME(a_cursor_range, i_clk, i_rst_n, 1'b1, r_cursor <= CUR_END, "cursor past end")
    `TCW_ASSERT_SAME(a_busy_stalls, i_clk, i_rst_n, r_state != tcw_pkg::ST_IDLE, o_stall, "request taken while busy")
    `TCW_ASSERT_SAME(a_walk_no_result, i_clk, i_rst_n, r_state == tcw_pkg::ST_COPY || r_state == tcw_pkg::ST_FILL || r_state == tcw_pkg::ST_CLEAR, !r_out_valid, "result shown during memory walk")
    `TCW_ASSERT_NEXT(a_hold_cursor, i_clk, i_rst_n, r_out_valid && i_stall, $stable(r_cursor), "cursor moved under stalled result")

endmodule

// ----- rtl/core/tcw_screen_ram.sv -----
// Screen cell store: one write port, one read port, registered read data.
// No package dependencies; instantiated by text_console_writer_unit.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for text_console_writer_unit: drives put, clear, read and
// unused-kind requests and attribute writes, mirrors the screen store and cursor in
// a local predictor, and compares every result. Depends on tcw_pkg and the RTL of the unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = tcw_pkg::COLS_DEFAULT;
    localparam int ROWS = tcw_pkg::ROWS_DEFAULT;
    localparam int CELLS = COLS * ROWS;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    tcw_pkg::t_in_req    i_req = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    tcw_pkg::t_out_res   o_res;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [7:0]          i_cfg_data = '0;

    logic [15:0]         screen_model [CELLS];
    int unsigned         cursor_model;
    logic [7:0]          attr_model;
    tcw_pkg::t_out_res   due_results [$];

    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int hold_off_len = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int scrolls_seen = 0;
    int clears_seen = 0;
    int attr_writes = 0;

    text_console_writer_unit #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic tcw_pkg::t_out_res console_apply(input tcw_pkg::t_in_req rq);
        tcw_pkg::t_out_res r;
        int unsigned       i;
        r = '0;
        case (rq.kind)
            tcw_pkg::KIND_PUT: begin
                if (rq.char_code != tcw_pkg::CODE_TERM) begin
                    if (cursor_model >= CELLS) begin
                        for (i = 0; i < CELLS - COLS; i++)
                            screen_model[i] = screen_model[i + COLS];
                        for (i = CELLS - COLS; i < CELLS; i++)
                            screen_model[i] = {attr_model, tcw_pkg::CODE_SPACE};
                        cursor_model -= COLS;
                        scrolls_seen++;
                    end
                    if (rq.char_code == tcw_pkg::CODE_NEWLINE) begin
                        cursor_model = (cursor_model / COLS + 1) * COLS;
                    end else begin
                        screen_model[cursor_model] = {attr_model, rq.char_code};
                        cursor_model++;
                    end
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    screen_model[i] = {attr_model, tcw_pkg::CODE_SPACE};
                cursor_model = 0;
                clears_seen++;
            end
            tcw_pkg::KIND_READ: begin
                if (rq.cell_index < CELLS) begin
                    r.cell_char = screen_model[rq.cell_index][7:0];
                    r.cell_attr = screen_model[rq.cell_index][15:8];
                end
            end
            default: ;
        endcase
        r.cursor_pos = cursor_model[10:0];
        return r;
    endfunction

    function automatic tcw_pkg::t_in_req make_request(input logic [1:0] kind,
                                                      input logic [7:0] code,
                                                      input logic [10:0] index);
        tcw_pkg::t_in_req rq;
        rq.kind = kind;
        rq.char_code = code;
        rq.cell_index = index;
        return rq;
    endfunction

    function automatic tcw_pkg::t_in_req random_request();
        tcw_pkg::t_in_req rq;
        int               r;
        int               near;
        r = $urandom_range(0, 99);
        rq.char_code = 8'($urandom_range(0, 255));
        rq.cell_index = 11'($urandom_range(0, 2047));
        if (r < 70) begin
            rq.kind = tcw_pkg::KIND_PUT;
            r = $urandom_range(0, 99);
            if (r < 12)
                rq.char_code = tcw_pkg::CODE_NEWLINE;
            else if (r < 15)
                rq.char_code = tcw_pkg::CODE_TERM;
            else
                rq.char_code = 8'($urandom_range(1, 255));
        end else if (r < 94) begin
            rq.kind = tcw_pkg::KIND_READ;
            if ($urandom_range(0, 1) == 1) begin
                near = int'(cursor_model) - int'($urandom_range(1, 2 * COLS));
                if (near < 0) near = 0;
                rq.cell_index = near[10:0];
            end
        end else if (r < 96) begin
            rq.kind = tcw_pkg::KIND_CLEAR;
        end else begin
            rq.kind = KIND_UNUSED;
        end
        return rq;
    endfunction

    task automatic send_request(input tcw_pkg::t_in_req rq);
        int gap;
        i_valid <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (o_stall);
        due_results.push_back(console_apply(rq));
        requests_sent++;
        gap = tx_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        attr_model = value;
        attr_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_contents();
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'd0));
        send_request(make_request(tcw_pkg::KIND_READ, 8'hFF, 11'd1999));
        send_request(make_request(tcw_pkg::KIND_PUT, tcw_pkg::CODE_TERM, 11'h7FF));
        send_request(make_request(KIND_UNUSED, 8'hFF, 11'h7FF));
    endtask

    task automatic test_put_and_read();
        send_request(make_request(tcw_pkg::KIND_PUT, 8'hFF, 11'd0));
        send_request(make_request(tcw_pkg::KIND_PUT, 8'h01, 11'h7FF));
        send_request(make_request(tcw_pkg::KIND_PUT, 8'h7E, 11'd0));
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'd0));
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'd1));
        send_request(make_request(tcw_pkg::KIND_READ, 8'hFF, 11'h7FF));
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'(CELLS)));
    endtask

    task automatic test_scroll_at_end();
        send_request(make_request(tcw_pkg::KIND_CLEAR, 8'h00, 11'd0));
        repeat (ROWS - 1)
            send_request(make_request(tcw_pkg::KIND_PUT, tcw_pkg::CODE_NEWLINE, 11'd0));
        send_request(make_request(tcw_pkg::KIND_PUT, 8'hFF, 11'd0));
        send_request(make_request(tcw_pkg::KIND_PUT, tcw_pkg::CODE_NEWLINE, 11'd0));
        send_request(make_request(tcw_pkg::KIND_PUT, tcw_pkg::CODE_TERM, 11'd0));
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'(CELLS - COLS)));
        send_request(make_request(tcw_pkg::KIND_PUT, 8'h01, 11'd0));
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'(CELLS - 2 * COLS)));
        send_request(make_request(tcw_pkg::KIND_READ, 8'h00, 11'(CELLS - 1)));
    endtask

    task automatic test_receiver_hold_off();
        wait_results_drained();
        tx_gaps_on = 1'b0;
        hold_off_len = 200;
        repeat (24) send_request(random_request());
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] attr,
                                       input bit gaps, input bit stalls);
        wait_results_drained();
        write_attribute(attr);
        tx_gaps_on = gaps;
        rx_stalls_on = stalls;
        repeat (count) send_request(random_request());
    endtask

    always begin : receiver_stalls
        int len;
        @(posedge i_clk);
        if (hold_off_len > 0) begin
            len = hold_off_len;
            hold_off_len = 0;
            i_stall <= 1'b1;
            repeat (len) @(posedge i_clk);
            i_stall <= 1'b0;
        end else if (rx_stalls_on) begin
            len = idle_len();
            if (len > 0) begin
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        tcw_pkg::t_out_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result cursor=%0d char=%0h attr=%0h", $time,
                         o_res.cursor_pos, o_res.cell_char, o_res.cell_attr);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                results_checked++;
                if (o_res.cursor_pos !== want.cursor_pos || o_res.cell_char !== want.cell_char
                        || o_res.cell_attr !== want.cell_attr) begin
                    $display("%0t: expected cursor=%0d char=%0h attr=%0h,", $time,
                             want.cursor_pos, want.cell_char, want.cell_attr);
                    $display("%0t: actual cursor=%0d char=%0h attr=%0h", $time,
                             o_res.cursor_pos, o_res.cell_char, o_res.cell_attr);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #80_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : run_tests
        int i;
        for (i = 0; i < CELLS; i++) screen_model[i] = '0;
        cursor_model = 0;
        attr_model = tcw_pkg::ATTR_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_put_and_read();
        test_scroll_at_end();
        test_random_traffic(420, 8'h00, 1'b1, 1'b1);
        test_random_traffic(420, 8'hFF, 1'b0, 1'b0);
        test_receiver_hold_off();
        test_random_traffic(470, 8'($urandom_range(1, 254)), 1'b1, 1'b1);
        test_random_traffic(470, 8'($urandom_range(0, 255)), 1'b1, 1'b0);

        wait_results_drained();
        repeat (16) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: %0d scrolls, %0d clears,",
                 requests_sent, results_checked, scrolls_seen, clears_seen);
        $display("%0d attribute writes, receiver hold-off and back-pressure phases.",
                 attr_writes);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- text_console_writer_unit.f -----
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_screen_ram.sv
rtl/core/text_console_writer_unit.sv
tb/testbench.sv
